// File: src/fgab_pkg.sv
// Shared types and constants for the font glyph alpha blender.
`timescale 1ns / 1ps

package fgab_pkg;

    // Atlas geometry and character mapping
    localparam int CELL_COUNT = 96;
    localparam int ATLAS_COLS = 16;
    localparam int ATLAS_ROWS = 6;
    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd126;
    localparam logic [7:0] CHAN_MAX   = 8'd255;

    // Item kinds carried on tuser
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_BLEND = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TEXT_RED   = 2'd0,
        REG_TEXT_GREEN = 2'd1,
        REG_TEXT_BLUE  = 2'd2
    } cfg_reg_t;

    // One RGB pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

endpackage

// File: src/fgab_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module fgab_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 12288
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/fgab_blend.sv
// Two-stage blend pipeline: products and sum, then division by 255.
`timescale 1ns / 1ps

module fgab_blend import fgab_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  rgb_t bg,
    input  rgb_t fnt,
    input  rgb_t txt,
    output logic out_valid,
    input  logic out_ready,
    output rgb_t out_pix
);

    logic        sum_valid_reg;
    logic [15:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic        out_valid_reg;
    rgb_t        out_pix_reg;
    logic        out_load;
    logic        sum_load;

    // Weighted sum of background and text colour for one channel
    function automatic logic [15:0] mix(input logic [7:0] b, input logic [7:0] f,
                                        input logic [7:0] t);
        logic [15:0] p0;
        logic [15:0] p1;
        p0 = 16'(b) * 16'(f);
        p1 = 16'(t) * 16'(CHAN_MAX - f);
        return p0 + p1;
    endfunction

    // Exact x/255 for x below 65280 by reciprocal with correction
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] t;
        t = x + {8'd0, x[15:8]} + 16'd1;
        return t[15:8];
    endfunction

    // Advance each stage when the next one can take it
    assign out_load = !out_valid_reg || out_ready;
    assign sum_load = !sum_valid_reg || out_load;
    assign in_ready = sum_load;

    // Sum stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sum_load) begin
            sum_valid_reg <= in_valid;
        end
        if (sum_load) begin
            sum_r_reg <= mix(bg.red,   fnt.red,   txt.red);
            sum_g_reg <= mix(bg.green, fnt.green, txt.green);
            sum_b_reg <= mix(bg.blue,  fnt.blue,  txt.blue);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= sum_valid_reg;
        end
        if (out_load) begin
            out_pix_reg.red   <= div255(sum_r_reg);
            out_pix_reg.green <= div255(sum_g_reg);
            out_pix_reg.blue  <= div255(sum_b_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;

endmodule

// File: src/font_glyph_alpha_blend.sv
// A blend result is registered by the RAM read stage, the weighted sum and the output register.
// Throughput: one item per cycle unless m_tready stalls, set by the single atlas RAM read port
// feeding a three-register pipeline (RAM read, weighted sum, divide by 255).
// Reset clears the pipeline valids and the text colour to zero; the font atlas RAM
// is not cleared and holds undefined data until loaded.
`timescale 1ns / 1ps

module font_glyph_alpha_blend import fgab_pkg::*; #(
    parameter int GLYPH_W = 8,
    parameter int GLYPH_H = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // char_code[7:0], glyph_col[10:8], glyph_row[14:11], pix_red[22:15],
    // pix_green[30:23], pix_blue[38:31], zero fill[39]
    input  logic [39:0] s_tdata,
    // action[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int DEPTH  = CELL_COUNT * GLYPH_W * GLYPH_H;
    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic [7:0]        char_code;
    logic [2:0]        glyph_col;
    logic [3:0]        glyph_row;
    rgb_t              pix_in;
    logic [6:0]        glyph_idx;
    logic              in_cell;
    logic [ADDR_W-1:0] addr;
    logic              accept;
    logic              ram_we;
    logic [23:0]       ram_rdata;

    logic [7:0] text_red_reg, text_green_reg, text_blue_reg;
    logic       rd_valid_reg;
    logic       rd_inside_reg;
    rgb_t       rd_bg_reg;
    logic       rd_load;
    logic       blend_ready;
    rgb_t       fnt_pix;
    rgb_t       txt_pix;
    rgb_t       out_pix;

    // Unpack the input transaction
    assign char_code    = s_tdata[7:0];
    assign glyph_col    = s_tdata[10:8];
    assign glyph_row    = s_tdata[14:11];
    assign pix_in.red   = s_tdata[22:15];
    assign pix_in.green = s_tdata[30:23];
    assign pix_in.blue  = s_tdata[38:31];

    // Map the code to a cell, non-printables to space
    always_comb begin
        logic [7:0] ofs;
        if (char_code < FIRST_CODE || char_code > LAST_CODE) begin
            ofs = 8'd0;
        end else begin
            ofs = char_code - FIRST_CODE;
        end
        glyph_idx = ofs[6:0];
    end

    assign in_cell = (7'(glyph_col) < 7'(GLYPH_W)) && (7'(glyph_row) < 7'(GLYPH_H));
    assign addr    = (ADDR_W'(glyph_idx) * ADDR_W'(GLYPH_H) + ADDR_W'(glyph_row))
                     * ADDR_W'(GLYPH_W) + ADDR_W'(glyph_col);

    // Read stage advances when the blend pipeline can take its item
    assign rd_load  = !rd_valid_reg || blend_ready;
    assign s_tready = rd_load;
    assign accept   = s_tvalid && s_tready;
    assign ram_we   = accept && (s_tuser[0] == ACT_LOAD) && in_cell;

    fgab_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_atlas (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (addr),
        .wdata ({pix_in.red, pix_in.green, pix_in.blue}),
        .re    (rd_load),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    // Hold the background and position flag beside the RAM read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (rd_load) begin
            rd_valid_reg <= accept && (s_tuser[0] == ACT_BLEND);
        end
        if (rd_load) begin
            rd_inside_reg <= in_cell;
            rd_bg_reg     <= pix_in;
        end
    end

    // Outside the cell the font is fully transparent
    always_comb begin
        if (rd_inside_reg) begin
            fnt_pix.red   = ram_rdata[23:16];
            fnt_pix.green = ram_rdata[15:8];
            fnt_pix.blue  = ram_rdata[7:0];
        end else begin
            fnt_pix.red   = CHAN_MAX;
            fnt_pix.green = CHAN_MAX;
            fnt_pix.blue  = CHAN_MAX;
        end
    end

    // Text colour registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_red_reg   <= 8'd0;
            text_green_reg <= 8'd0;
            text_blue_reg  <= 8'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TEXT_RED:   text_red_reg   <= cfg_data;
                REG_TEXT_GREEN: text_green_reg <= cfg_data;
                REG_TEXT_BLUE:  text_blue_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign txt_pix.red   = text_red_reg;
    assign txt_pix.green = text_green_reg;
    assign txt_pix.blue  = text_blue_reg;

    fgab_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid_reg),
        .in_ready  (blend_ready),
        .bg        (rd_bg_reg),
        .fnt       (fnt_pix),
        .txt       (txt_pix),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix)
    );

    assign m_tdata = {out_pix.blue, out_pix.green, out_pix.red};

endmodule

// File: test/tb_font_glyph_alpha_blend.sv
// Self-checking testbench for the font glyph alpha blender: atlas loads, blends, color changes.
`timescale 1ns / 1ps

module tb_font_glyph_alpha_blend;
    import fgab_pkg::*;

    localparam int GLYPH_W        = 8;
    localparam int GLYPH_H        = 16;
    localparam int ATLAS_DEPTH    = CELL_COUNT * GLYPH_W * GLYPH_H;
    localparam int PIPE_DRAIN     = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 300;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // char_code[7:0], glyph_col[10:8], glyph_row[14:11], pix_red[22:15],
    // pix_green[30:23], pix_blue[38:31], zero fill[39]
    logic [39:0] s_tdata   = '0;
    // action[0]
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_TEXT_RED;
    logic [7:0]  cfg_data  = '0;

    font_glyph_alpha_blend #(
        .GLYPH_W(GLYPH_W),
        .GLYPH_H(GLYPH_H)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Map a character byte to its glyph index; non-printable codes fall back to space
    function automatic int glyph_slot(logic [7:0] code);
        logic [7:0] c;
        c = (code < FIRST_CODE || code > LAST_CODE) ? FIRST_CODE : code;
        return int'(c - FIRST_CODE);
    endfunction

    function automatic int atlas_addr(logic [7:0] code, logic [2:0] col, logic [3:0] row);
        return (glyph_slot(code) * GLYPH_H + int'(row)) * GLYPH_W + int'(col);
    endfunction

    class overlay_scoreboard;
        rgb_t glyph_mem [ATLAS_DEPTH];
        rgb_t text_colour;
        rgb_t expected_pixels [$];
        int   errors;
        int   results_checked;
        int   loads_seen;
        int   blends_seen;

        function new();
            text_colour     = '0;
            errors          = 0;
            results_checked = 0;
            loads_seen      = 0;
            blends_seen     = 0;
        endfunction

        function void set_colour(logic [1:0] idx, logic [7:0] val);
            case (idx)
                REG_TEXT_RED:   text_colour.red   = val;
                REG_TEXT_GREEN: text_colour.green = val;
                REG_TEXT_BLUE:  text_colour.blue  = val;
                default: ;
            endcase
        endfunction

        // (background*font + text*(255-font)) / 255, truncated
        function logic [7:0] mix_channel(logic [7:0] bg, logic [7:0] fnt, logic [7:0] txt);
            int unsigned acc;
            acc = int'(bg) * int'(fnt) + int'(txt) * (int'(CHAN_MAX) - int'(fnt));
            return 8'(acc / int'(CHAN_MAX));
        endfunction

        // Apply one accepted input transaction; blends queue their expected pixel.
        // Column and row fields are exactly as wide as the cell, so every
        // position falls inside the glyph.
        function void note_input(logic act, logic [39:0] data);
            logic [7:0] code;
            logic [2:0] col;
            logic [3:0] row;
            rgb_t       pix;
            rgb_t       fnt;
            rgb_t       mixed;
            int         addr;
            code      = data[7:0];
            col       = data[10:8];
            row       = data[14:11];
            pix.red   = data[22:15];
            pix.green = data[30:23];
            pix.blue  = data[38:31];
            addr      = atlas_addr(code, col, row);
            if (act == ACT_LOAD) begin
                glyph_mem[addr] = pix;
                loads_seen++;
            end else begin
                fnt         = glyph_mem[addr];
                mixed.red   = mix_channel(pix.red, fnt.red, text_colour.red);
                mixed.green = mix_channel(pix.green, fnt.green, text_colour.green);
                mixed.blue  = mix_channel(pix.blue, fnt.blue, text_colour.blue);
                expected_pixels.push_back(mixed);
                blends_seen++;
            end
        endfunction

        function void check_result(logic [23:0] data);
            rgb_t want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result transaction: %h", data);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            results_checked++;
            if (data[7:0] !== want.red) begin
                $error("out_red mismatch: expected %0d, actual %0d", want.red, data[7:0]);
                errors++;
            end
            if (data[15:8] !== want.green) begin
                $error("out_green mismatch: expected %0d, actual %0d", want.green, data[15:8]);
                errors++;
            end
            if (data[23:16] !== want.blue) begin
                $error("out_blue mismatch: expected %0d, actual %0d", want.blue, data[23:16]);
                errors++;
            end
        endfunction
    endclass

    overlay_scoreboard sb;

    // Atlas entries loaded so far; blends only read these
    bit loaded [ATLAS_DEPTH];
    int loaded_addrs [$];

    bit tx_gaps         = 1'b0;
    bit rx_gaps         = 1'b0;
    bit quiet           = 1'b0;
    int stall_left      = 0;
    int idle_cycles     = 0;
    int colour_settings = 1;

    // Observe every accepted transaction on all three channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.set_colour(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Stall the result side in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0)
            stall_left--;
        else if (rx_gaps && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 7);
        m_tready <= aresetn && stall_left == 0;
    end

    // Abort when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return CHAN_MAX;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic rgb_t rand_pixel();
        rgb_t p;
        p.red   = rand_chan();
        p.green = rand_chan();
        p.blue  = rand_chan();
        return p;
    endfunction

    // Present one item and hold it until accepted
    task automatic send_item(input logic act, input logic [7:0] code, input logic [2:0] col,
                             input logic [3:0] row, input rgb_t pix);
        int addr;
        addr = atlas_addr(code, col, row);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, pix.blue, pix.green, pix.red, row, col, code};
        do @(posedge aclk); while (!s_tready);
        if (act == ACT_LOAD && !loaded[addr]) begin
            loaded[addr] = 1'b1;
            loaded_addrs.push_back(addr);
        end
    endtask

    // Hold off the sender until every blended pixel has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic write_colours(input rgb_t c);
        cfg_reg_t   idx;
        logic [7:0] val;
        for (int i = 0; i < 3; i++) begin
            idx = cfg_reg_t'(i);
            case (idx)
                REG_TEXT_RED:   val = c.red;
                REG_TEXT_GREEN: val = c.green;
                default:        val = c.blue;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        colour_settings++;
    endtask

    // Field extremes, non-printable codes and read right after write
    task automatic run_directed();
        send_item(ACT_LOAD,  8'd32,  3'd0, 4'd0,  '{8'd0,   8'd0,   8'd0});
        send_item(ACT_LOAD,  8'd0,   3'd7, 4'd15, '{8'd255, 8'd255, 8'd255});
        send_item(ACT_LOAD,  8'd126, 3'd7, 4'd15, '{8'd255, 8'd0,   8'd128});
        send_item(ACT_LOAD,  8'd255, 3'd3, 4'd5,  '{8'd1,   8'd254, 8'd127});
        send_item(ACT_LOAD,  8'd33,  3'd0, 4'd0,  '{8'd170, 8'd85,  8'd15});
        send_item(ACT_LOAD,  8'd127, 3'd1, 4'd1,  '{8'd128, 8'd128, 8'd128});
        send_item(ACT_BLEND, 8'd32,  3'd0, 4'd0,  '{8'd255, 8'd255, 8'd255});
        send_item(ACT_BLEND, 8'd0,   3'd7, 4'd15, '{8'd12,  8'd200, 8'd255});
        send_item(ACT_BLEND, 8'd31,  3'd7, 4'd15, '{8'd0,   8'd0,   8'd0});
        send_item(ACT_BLEND, 8'd126, 3'd7, 4'd15, '{8'd255, 8'd255, 8'd255});
        send_item(ACT_BLEND, 8'd200, 3'd3, 4'd5,  '{8'd77,  8'd88,  8'd99});
        send_item(ACT_BLEND, 8'd33,  3'd0, 4'd0,  '{8'd255, 8'd0,   8'd255});
        send_item(ACT_BLEND, 8'd127, 3'd1, 4'd1,  '{8'd10,  8'd20,  8'd30});
        send_item(ACT_BLEND, 8'd255, 3'd0, 4'd0,  '{8'd255, 8'd255, 8'd255});
        send_item(ACT_LOAD,  8'd126, 3'd0, 4'd0,  '{8'd0,   8'd0,   8'd0});
        send_item(ACT_BLEND, 8'd126, 3'd0, 4'd0,  '{8'd200, 8'd100, 8'd50});
        send_item(ACT_LOAD,  8'd126, 3'd0, 4'd0,  '{8'd255, 8'd255, 8'd255});
        send_item(ACT_BLEND, 8'd126, 3'd0, 4'd0,  '{8'd200, 8'd100, 8'd50});
    endtask

    // Random loads and blends; blends only address entries already loaded
    task automatic run_random(input int count);
        int         addr;
        int         slot;
        int         pick;
        logic [7:0] code;
        logic [2:0] col;
        logic [3:0] row;
        for (int k = 0; k < count; k++) begin
            if (k % 60 == 0) begin
                tx_gaps = !quiet && $urandom_range(0, 2) != 0;
                rx_gaps = !quiet && $urandom_range(0, 2) != 0;
            end
            if (!quiet && k == count / 2 && $urandom_range(0, 1) == 0)
                drain_results();
            if (loaded_addrs.size() == 0 || $urandom_range(0, 9) < 4) begin
                // Half the loads land in a few hot glyphs so blends see rewrites
                if ($urandom_range(0, 1) == 0)
                    code = 8'($urandom_range(32, 40));
                else
                    code = 8'($urandom_range(0, 255));
                send_item(ACT_LOAD, code, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                          rand_pixel());
            end else begin
                addr = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
                col  = 3'(addr % GLYPH_W);
                row  = 4'((addr / GLYPH_W) % GLYPH_H);
                slot = addr / (GLYPH_W * GLYPH_H);
                code = 8'(slot) + FIRST_CODE;
                // The space glyph is also reached through non-printable codes
                if (slot == 0) begin
                    pick = $urandom_range(0, 2);
                    if (pick == 1)
                        code = 8'($urandom_range(0, 31));
                    else if (pick == 2)
                        code = 8'($urandom_range(127, 255));
                end
                send_item(ACT_BLEND, code, col, row, rand_pixel());
            end
        end
    endtask

    initial begin
        rgb_t phase_colour [4];
        sb = new();
        phase_colour[0] = '{8'd255, 8'd255, 8'd255};
        phase_colour[1] = '{8'd0,   8'd200, 8'd0};
        phase_colour[2] = '{8'd255, 8'd0,   8'd77};
        phase_colour[3] = rand_pixel();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // First phase runs on the reset text color
        rx_gaps = 1'b1;
        run_directed();
        run_random(PHASE_ITEMS);

        // Change the text color only with the pipeline empty; last phase runs without idling
        for (int p = 0; p < 4; p++) begin
            drain_results();
            quiet = (p == 3);
            write_colours(phase_colour[p]);
            run_random(PHASE_ITEMS);
        end
        drain_results();

        $display("Ran %0d atlas loads and %0d blends under %0d text colors; %0d pixels checked.",
                 sb.loads_seen, sb.blends_seen, colour_settings, sb.results_checked);
        $display("Blends covered printable and non-printable codes with random stalls on both sides.");
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
src/fgab_pkg.sv
src/fgab_ram.sv
src/fgab_blend.sv
src/font_glyph_alpha_blend.sv
test/tb_font_glyph_alpha_blend.sv
